### sv/qau_pkg.sv
// Shared types, constants and saturating helpers for the quaternion arithmetic unit.
// No dependencies; every other file refers to this package by scoped names.
package qau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PORT_W         = 32;
    localparam int W_MAX          = 64;

    // multiplier: partial products, then sum/shift/saturate
    localparam int MUL_LAT = 2;
    localparam int LAT_HAM = MUL_LAT + 3;
    localparam int LAT_ROT = 2 * MUL_LAT + 4;
    localparam int LAT_MAT = MUL_LAT + 3;

    localparam int ROWS = 3;

    // component positions in quaternion and vector arrays
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ROT = 2'd1,
        OP_MAT = 2'd2
    } t_op;

    typedef logic signed [W_MAX-1:0] t_wide;
    typedef logic signed [W_MAX:0]   t_ext;

    function automatic t_wide f_clamp(input t_ext v, input int dw);
        t_ext hi;
        t_ext lo;
        hi = (t_ext'(1) <<< (dw - 1)) - t_ext'(1);
        lo = -hi - t_ext'(1);
        if (v > hi) return t_wide'(hi);
        if (v < lo) return t_wide'(lo);
        return t_wide'(v);
    endfunction

    function automatic t_wide f_sadd(input t_wide a, input t_wide b, input int dw);
        return f_clamp(t_ext'(a) + t_ext'(b), dw);
    endfunction

    function automatic t_wide f_ssub(input t_wide a, input t_wide b, input int dw);
        return f_clamp(t_ext'(a) - t_ext'(b), dw);
    endfunction

endpackage

### sv/qau_mul.sv
// Two-stage signed fixed-point multiplier: split partial products, then
// sum, arithmetic shift by the fraction width and saturate. Uses qau_pkg.
module qau_mul #(
    parameter int DW = qau_pkg::DATA_WIDTH_DEF,
    parameter int FB = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_p
);

    localparam int H  = (DW + 1) / 2;
    localparam int HW = DW - H;
    localparam int LW = H + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic signed [HW-1:0]    a_hi, b_hi;
    logic signed [LW-1:0]    a_lo, b_lo;
    logic signed [2*HW-1:0]  n_hh, r_hh;
    logic signed [HW+LW-1:0] n_hl, r_hl, n_lh, r_lh;
    logic signed [2*LW-1:0]  n_ll, r_ll;
    logic signed [PW-1:0]    full, shr;
    logic [PW-DW:0]          top;
    logic signed [DW-1:0]    n_p, r_p;

    assign a_hi = i_a[DW-1:H];
    assign b_hi = i_b[DW-1:H];
    assign a_lo = {1'b0, i_a[H-1:0]};
    assign b_lo = {1'b0, i_b[H-1:0]};

    assign n_hh = a_hi * b_hi;
    assign n_hl = a_hi * b_lo;
    assign n_lh = a_lo * b_hi;
    assign n_ll = a_lo * b_lo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
        end
    end

    always_comb begin
        full = (PW'(r_hh) <<< (2 * H)) + (PW'(r_hl) <<< H) + (PW'(r_lh) <<< H) + PW'(r_ll);
        shr  = full >>> FB;
        top  = shr[PW-1:DW-1];
        // in range only if every bit above the result sign matches it
        if ((&top) || !(|top)) begin
            n_p = shr[DW-1:0];
        end else begin
            n_p = full[PW-1] ? MINV : MAXV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

### sv/qau_ham.sv
// Hamilton product pipeline: sixteen multipliers, then three saturating add stages.
// Depends on qau_pkg and qau_mul.
module qau_ham #(
    parameter int DW = qau_pkg::DATA_WIDTH_DEF,
    parameter int FB = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a [4],
    input  logic signed [DW-1:0] i_b [4],
    output logic signed [DW-1:0] o_q [4]
);

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_sadd(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_ssub(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    logic signed [DW-1:0] ma [16];
    logic signed [DW-1:0] mb [16];
    logic signed [DW-1:0] p  [16];
    logic signed [DW-1:0] r_s1 [4];
    logic signed [DW-1:0] r_s2 [4];
    logic signed [DW-1:0] r_s3 [4];
    logic signed [DW-1:0] r_t2 [4];
    logic signed [DW-1:0] r_t3a [4];
    logic signed [DW-1:0] r_t3b [4];

    // vector parts: w*b_i + a_i*bw + a_j*b_k - a_k*b_j
    for (genvar c = 0; c < 3; c++) begin : g_vec
        localparam int J = (c + 1) % 3;
        localparam int K = (c + 2) % 3;
        assign ma[4*c]   = i_a[qau_pkg::IW];
        assign mb[4*c]   = i_b[c];
        assign ma[4*c+1] = i_a[c];
        assign mb[4*c+1] = i_b[qau_pkg::IW];
        assign ma[4*c+2] = i_a[J];
        assign mb[4*c+2] = i_b[K];
        assign ma[4*c+3] = i_a[K];
        assign mb[4*c+3] = i_b[J];
    end

    // scalar part: w*bw - x*bx - y*by - z*bz
    assign ma[12] = i_a[qau_pkg::IW];
    assign mb[12] = i_b[qau_pkg::IW];
    assign ma[13] = i_a[qau_pkg::IX];
    assign mb[13] = i_b[qau_pkg::IX];
    assign ma[14] = i_a[qau_pkg::IY];
    assign mb[14] = i_b[qau_pkg::IY];
    assign ma[15] = i_a[qau_pkg::IZ];
    assign mb[15] = i_b[qau_pkg::IZ];

    for (genvar m = 0; m < 16; m++) begin : g_mul
        qau_mul #(.DW(DW), .FB(FB)) u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (ma[m]),
            .i_b   (mb[m]),
            .o_p   (p[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_s1[c]  <= (c == qau_pkg::IW) ? ssub(p[4*c], p[4*c+1])
                                               : sadd(p[4*c], p[4*c+1]);
                r_t2[c]  <= p[4*c+2];
                r_t3a[c] <= p[4*c+3];
                r_s2[c]  <= (c == qau_pkg::IW) ? ssub(r_s1[c], r_t2[c])
                                               : sadd(r_s1[c], r_t2[c]);
                r_t3b[c] <= r_t3a[c];
                r_s3[c]  <= ssub(r_s2[c], r_t3b[c]);
            end
        end
    end

    assign o_q = r_s3;

endmodule

### sv/qau_rot.sv
// Vector rotation pipeline: cross product, second cross product and scale by 2w,
// then saturating accumulation. Depends on qau_pkg and qau_mul.
module qau_rot #(
    parameter int DW = qau_pkg::DATA_WIDTH_DEF,
    parameter int FB = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_q [4],
    input  logic signed [DW-1:0] i_v [4],
    output logic signed [DW-1:0] o_r [3]
);

    localparam int QD = qau_pkg::MUL_LAT + 1;
    localparam int VD = 2 * qau_pkg::MUL_LAT + 1;

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_sadd(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_ssub(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    logic signed [DW-1:0] ma1 [6];
    logic signed [DW-1:0] mb1 [6];
    logic signed [DW-1:0] p1  [6];
    logic signed [DW-1:0] ma2 [6];
    logic signed [DW-1:0] mb2 [6];
    logic signed [DW-1:0] p2  [6];
    logic signed [DW-1:0] p3  [3];
    logic signed [DW-1:0] r_qd  [QD][3];
    logic signed [DW-1:0] r_vd  [VD][3];
    logic signed [DW-1:0] r_tw  [QD];
    logic signed [DW-1:0] r_uv  [3];
    logic signed [DW-1:0] r_uuv [3];
    logic signed [DW-1:0] r_duv [3];
    logic signed [DW-1:0] r_s1  [3];
    logic signed [DW-1:0] r_s2  [3];
    logic signed [DW-1:0] r_res [3];

    // cross product terms: r_i = p_j*q_k - p_k*q_j
    for (genvar i = 0; i < 3; i++) begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        assign ma1[2*i]   = i_q[J];
        assign mb1[2*i]   = i_v[K];
        assign ma1[2*i+1] = i_q[K];
        assign mb1[2*i+1] = i_v[J];
        assign ma2[2*i]   = r_qd[QD-1][J];
        assign mb2[2*i]   = r_uv[K];
        assign ma2[2*i+1] = r_qd[QD-1][K];
        assign mb2[2*i+1] = r_uv[J];
    end

    for (genvar m = 0; m < 6; m++) begin : g_mul
        qau_mul #(.DW(DW), .FB(FB)) u_mul1 (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (ma1[m]),
            .i_b   (mb1[m]),
            .o_p   (p1[m])
        );
        qau_mul #(.DW(DW), .FB(FB)) u_mul2 (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (ma2[m]),
            .i_b   (mb2[m]),
            .o_p   (p2[m])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_scale
        qau_mul #(.DW(DW), .FB(FB)) u_mul3 (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (r_uv[i]),
            .i_b   (r_tw[QD-1]),
            .o_p   (p3[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tw[0] <= sadd(i_q[qau_pkg::IW], i_q[qau_pkg::IW]);
            for (int s = 1; s < QD; s++) begin
                r_tw[s] <= r_tw[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_qd[0][i] <= i_q[i];
                for (int s = 1; s < QD; s++) begin
                    r_qd[s][i] <= r_qd[s-1][i];
                end
                r_vd[0][i] <= i_v[i];
                for (int s = 1; s < VD; s++) begin
                    r_vd[s][i] <= r_vd[s-1][i];
                end
                r_uv[i]  <= ssub(p1[2*i], p1[2*i+1]);
                r_uuv[i] <= ssub(p2[2*i], p2[2*i+1]);
                r_s1[i]  <= sadd(r_vd[VD-1][i], p3[i]);
                r_duv[i] <= sadd(r_uuv[i], r_uuv[i]);
                r_s2[i]  <= r_s1[i];
                r_res[i] <= sadd(r_s2[i], r_duv[i]);
            end
        end
    end

    assign o_r = r_res;

endmodule

### sv/qau_mat.sv
// Rotation matrix pipeline: doubling, nine multipliers, pair sums, then 1 - sum
// on the diagonal. Output is row-major. Depends on qau_pkg and qau_mul.
module qau_mat #(
    parameter int DW = qau_pkg::DATA_WIDTH_DEF,
    parameter int FB = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_q [4],
    output logic signed [DW-1:0] o_m [9]
);

    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] ONE  = (FB <= DW - 2) ? (DW'(1) <<< FB) : MAXV;

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_sadd(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return DW'(qau_pkg::f_ssub(qau_pkg::t_wide'(a), qau_pkg::t_wide'(b), DW));
    endfunction

    logic signed [DW-1:0] r_t  [3];
    logic signed [DW-1:0] r_qd [4];
    logic signed [DW-1:0] ma [9];
    logic signed [DW-1:0] mb [9];
    logic signed [DW-1:0] p  [9];
    logic signed [DW-1:0] r_d   [3];
    logic signed [DW-1:0] r_off [6];
    logic signed [DW-1:0] r_m   [9];

    // products: 2xw 2yw 2zw 2xx 2yx 2zx 2yy 2zy 2zz
    assign ma[0] = r_t[qau_pkg::IX];
    assign mb[0] = r_qd[qau_pkg::IW];
    assign ma[1] = r_t[qau_pkg::IY];
    assign mb[1] = r_qd[qau_pkg::IW];
    assign ma[2] = r_t[qau_pkg::IZ];
    assign mb[2] = r_qd[qau_pkg::IW];
    assign ma[3] = r_t[qau_pkg::IX];
    assign mb[3] = r_qd[qau_pkg::IX];
    assign ma[4] = r_t[qau_pkg::IY];
    assign mb[4] = r_qd[qau_pkg::IX];
    assign ma[5] = r_t[qau_pkg::IZ];
    assign mb[5] = r_qd[qau_pkg::IX];
    assign ma[6] = r_t[qau_pkg::IY];
    assign mb[6] = r_qd[qau_pkg::IY];
    assign ma[7] = r_t[qau_pkg::IZ];
    assign mb[7] = r_qd[qau_pkg::IY];
    assign ma[8] = r_t[qau_pkg::IZ];
    assign mb[8] = r_qd[qau_pkg::IZ];

    for (genvar m = 0; m < 9; m++) begin : g_mul
        qau_mul #(.DW(DW), .FB(FB)) u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (ma[m]),
            .i_b   (mb[m]),
            .o_p   (p[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= sadd(i_q[i], i_q[i]);
            end
            r_qd <= i_q;
            // diagonal sums: yy+zz, xx+zz, xx+yy
            r_d[0]   <= sadd(p[6], p[8]);
            r_d[1]   <= sadd(p[3], p[8]);
            r_d[2]   <= sadd(p[3], p[6]);
            // off-diagonal: m01 m02 m10 m12 m20 m21
            r_off[0] <= ssub(p[4], p[2]);
            r_off[1] <= sadd(p[5], p[1]);
            r_off[2] <= sadd(p[4], p[2]);
            r_off[3] <= ssub(p[7], p[0]);
            r_off[4] <= ssub(p[5], p[1]);
            r_off[5] <= sadd(p[7], p[0]);
            r_m[0]   <= ssub(ONE, r_d[0]);
            r_m[1]   <= r_off[0];
            r_m[2]   <= r_off[1];
            r_m[3]   <= r_off[2];
            r_m[4]   <= ssub(ONE, r_d[1]);
            r_m[5]   <= r_off[3];
            r_m[6]   <= r_off[4];
            r_m[7]   <= r_off[5];
            r_m[8]   <= ssub(ONE, r_d[2]);
        end
    end

    assign o_m = r_m;

endmodule

### sv/quaternion_arith_unit.sv
// Quaternion arithmetic unit: multiply, rotate vector, rotation matrix in
// signed fixed point (default Q16.16, saturating).
//
// Command channel: present op, a_* and b_* with start high; the word is
// taken at a clock edge where start is high and busy is low.
// Result channel: each result word sits on o_out_* for one cycle with
// o_strobe high; o_last marks the final word of an item. The receiver
// cannot hold results off, so the unit never waits on it.
// A word passes through the input register, eight pipeline stages and the
// output register. Throughput: one multiply or rotate item per cycle while
// busy is low. A matrix item yields three row words on consecutive cycles;
// the single output register sets that, and busy is high while the pipeline
// holds: the cycle before row one reaches the ports and the cycle it sits
// there. Op code 3 is accepted and gives no word.
// Reset (i_rst_n low, synchronous) drops every item in flight and clears
// the strobe, the row counter and busy; the data registers are not reset.
// Depends on qau_pkg, qau_mul, qau_ham, qau_rot and qau_mat.
module quaternion_arith_unit #(
    parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_a_w,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_b_w,
    output logic               o_strobe,
    output logic signed [31:0] o_out_0,
    output logic signed [31:0] o_out_1,
    output logic signed [31:0] o_out_2,
    output logic signed [31:0] o_out_3,
    output logic               o_last
);

    localparam int DW    = DATA_WIDTH;
    localparam int PW    = qau_pkg::PORT_W;
    localparam int DEPTH = qau_pkg::LAT_ROT;
    localparam int PAD_H = qau_pkg::LAT_ROT - qau_pkg::LAT_HAM;
    localparam int PAD_M = qau_pkg::LAT_ROT - qau_pkg::LAT_MAT;
    localparam logic [1:0] LAST_ROW = 2'(qau_pkg::ROWS - 1);

    function automatic logic signed [DW-1:0] decode(input logic signed [31:0] v);
        return DW'(qau_pkg::f_clamp(qau_pkg::t_ext'(v), DW));
    endfunction

    logic                 r_v0;
    logic [1:0]           r_op0;
    logic signed [DW-1:0] r_a [4];
    logic signed [DW-1:0] r_b [4];
    logic                 r_v  [DEPTH];
    logic [1:0]           r_op [DEPTH];

    logic signed [DW-1:0] ham_q [4];
    logic signed [DW-1:0] rot_r [3];
    logic signed [DW-1:0] mat_m [9];
    logic signed [DW-1:0] r_hd [PAD_H][4];
    logic signed [DW-1:0] r_md [PAD_M][9];

    logic                 e_v;
    logic [1:0]           e_op;
    logic                 e_mat;
    logic                 stall;
    logic                 en;
    logic [1:0]           r_row;

    logic                 n_strobe, r_strobe;
    logic                 n_last, r_last;
    logic signed [PW-1:0] n_out [4];
    logic signed [PW-1:0] r_out [4];

    assign e_v   = r_v[DEPTH-1];
    assign e_op  = r_op[DEPTH-1];
    assign e_mat = e_v && (e_op == qau_pkg::OP_MAT);
    // hold the whole pipe while a matrix item still has rows to send
    assign stall = e_mat && (r_row != LAST_ROW);
    assign en    = !stall;
    assign busy  = stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v      <= '{default: 1'b0};
            r_row    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (en) begin
                r_v0 <= start;
                r_v[0] <= r_v0;
                for (int s = 1; s < DEPTH; s++) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            if (e_mat) begin
                r_row <= (r_row == LAST_ROW) ? 2'd0 : r_row + 2'd1;
            end
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (start) begin
                r_op0 <= i_op;
                r_a[qau_pkg::IX] <= decode(i_a_x);
                r_a[qau_pkg::IY] <= decode(i_a_y);
                r_a[qau_pkg::IZ] <= decode(i_a_z);
                r_a[qau_pkg::IW] <= decode(i_a_w);
                r_b[qau_pkg::IX] <= decode(i_b_x);
                r_b[qau_pkg::IY] <= decode(i_b_y);
                r_b[qau_pkg::IZ] <= decode(i_b_z);
                r_b[qau_pkg::IW] <= decode(i_b_w);
            end
            r_op[0] <= r_op0;
            for (int s = 1; s < DEPTH; s++) begin
                r_op[s] <= r_op[s-1];
            end
            // align the shorter pipelines with the rotate path
            r_hd[0] <= ham_q;
            for (int s = 1; s < PAD_H; s++) begin
                r_hd[s] <= r_hd[s-1];
            end
            r_md[0] <= mat_m;
            for (int s = 1; s < PAD_M; s++) begin
                r_md[s] <= r_md[s-1];
            end
        end
    end

    qau_ham #(.DW(DW), .FB(FRAC_BITS)) u_ham (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_q   (ham_q)
    );

    qau_rot #(.DW(DW), .FB(FRAC_BITS)) u_rot (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (r_a),
        .i_v   (r_b),
        .o_r   (rot_r)
    );

    qau_mat #(.DW(DW), .FB(FRAC_BITS)) u_mat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (r_a),
        .o_m   (mat_m)
    );

    always_comb begin
        n_out    = '{default: '0};
        n_strobe = 1'b0;
        n_last   = 1'b1;
        case (e_op)
            qau_pkg::OP_MUL: begin
                n_strobe = e_v;
                for (int k = 0; k < 4; k++) begin
                    n_out[k] = PW'(r_hd[PAD_H-1][k]);
                end
            end
            qau_pkg::OP_ROT: begin
                n_strobe = e_v;
                for (int k = 0; k < 3; k++) begin
                    n_out[k] = PW'(rot_r[k]);
                end
            end
            qau_pkg::OP_MAT: begin
                n_strobe = e_v;
                n_last   = (r_row == LAST_ROW);
                case (r_row)
                    2'd0: begin
                        for (int k = 0; k < 3; k++) begin
                            n_out[k] = PW'(r_md[PAD_M-1][k]);
                        end
                    end
                    2'd1: begin
                        for (int k = 0; k < 3; k++) begin
                            n_out[k] = PW'(r_md[PAD_M-1][3 + k]);
                        end
                    end
                    default: begin
                        for (int k = 0; k < 3; k++) begin
                            n_out[k] = PW'(r_md[PAD_M-1][6 + k]);
                        end
                    end
                endcase
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_strobe = r_strobe;
    assign o_out_0  = r_out[0];
    assign o_out_1  = r_out[1];
    assign o_out_2  = r_out[2];
    assign o_out_3  = r_out[3];
    assign o_last   = r_last;

`ifndef NO_ASSERTIONS
    a_busy_only_on_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_v[DEPTH-1] && (r_op[DEPTH-1] == qau_pkg::OP_MAT)))
        else $error("busy without a matrix item at the pipe end");

    a_rows_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("matrix row sequence broken");

    a_hold_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (r_v0 == $past(r_v0)))
        else $error("input stage moved while busy");

    a_row_count_tied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row != 2'd0) |-> (r_v[DEPTH-1] && (r_op[DEPTH-1] == qau_pkg::OP_MAT)))
        else $error("row counter running without a matrix item");
`endif

endmodule

### test/quaternion_arith_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quaternion_arith_unit: a directed table, then random words,
// each scored against an in-bench saturating fixed-point model of multiply, rotate, matrix.
// Depends on qau_pkg and the quaternion_arith_unit RTL.
module quaternion_arith_unit_tb;

    localparam int FB = qau_pkg::FRAC_BITS_DEF;
    localparam longint Q_HI = (64'sd1 <<< (qau_pkg::DATA_WIDTH_DEF - 1)) - 64'sd1;
    localparam longint Q_LO = -Q_HI - 64'sd1;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int N_DIR = 21;
    localparam int N_RAND = 200;
    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [31:0] t_q;

    localparam t_q ONE  = 32'sh0001_0000;
    localparam t_q HALF = 32'sh0000_8000;
    localparam t_q R45  = 32'sd46341;
    localparam t_q QMAX = 32'sh7fff_ffff;
    localparam t_q QMIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0] op;
        t_q ax, ay, az, aw, bx, by, bz, bw;
        logic typed;
        t_q e0, e1, e2, e3;
    } t_row;

    typedef struct packed {
        t_q c0, c1, c2, c3;
        logic last;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_op = '0;
    t_q i_a_x = '0, i_a_y = '0, i_a_z = '0, i_a_w = '0;
    t_q i_b_x = '0, i_b_y = '0, i_b_z = '0, i_b_w = '0;
    logic o_strobe;
    t_q o_out_0, o_out_1, o_out_2, o_out_3;
    logic o_last;

    t_word pending_words[$];
    t_word got_word;
    int n_errors = 0;
    int n_checked = 0;
    int n_ops[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    quaternion_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_op    (i_op),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_a_w   (i_a_w),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_b_w   (i_b_w),
        .o_strobe(o_strobe),
        .o_out_0 (o_out_0),
        .o_out_1 (o_out_1),
        .o_out_2 (o_out_2),
        .o_out_3 (o_out_3),
        .o_last  (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed words; typed rows carry the single result word to expect.
    t_row dir_rows [N_DIR] = '{
        '{qau_pkg::OP_MUL, 0, 0, 0, ONE, ONE, 2 * ONE, -3 * ONE, HALF,
          1'b1, ONE, 2 * ONE, -3 * ONE, HALF},
        '{qau_pkg::OP_MUL, 0, 0, 0, 0, QMAX, QMIN, QMAX, QMIN,
          1'b1, 0, 0, 0, 0},
        '{qau_pkg::OP_MUL, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX,
          1'b1, 0, 0, 0, QMIN},
        '{qau_pkg::OP_MUL, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN,
          1'b1, 0, 0, 0, QMIN},
        '{qau_pkg::OP_MUL, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN,
          1'b1, 0, 0, 0, QMAX},
        '{qau_pkg::OP_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0,
          1'b1, 0, 0, 0, -ONE},
        '{qau_pkg::OP_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0,
          1'b1, 0, 0, ONE, 0},
        '{qau_pkg::OP_MUL, 1, -1, 1, -1, -1, 1, 1, -1,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_ROT, 0, 0, 0, ONE, QMAX, QMIN, -1, QMAX,
          1'b1, QMAX, QMIN, -1, 0},
        '{qau_pkg::OP_ROT, 0, 0, 0, 0, ONE, -2 * ONE, HALF, QMIN,
          1'b1, ONE, -2 * ONE, HALF, 0},
        '{qau_pkg::OP_ROT, 0, 0, R45, R45, ONE, 0, 0, 0,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_ROT, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, 0,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_ROT, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_ROT, HALF, -HALF, HALF, HALF, ONE, 2 * ONE, 3 * ONE, 0,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_MAT, 0, 0, 0, ONE, 0, 0, 0, 0,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_MAT, 0, 0, 0, 0, QMAX, QMIN, QMAX, QMIN,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_MAT, QMAX, QMAX, QMAX, QMAX, 0, 0, 0, 0,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_MAT, QMIN, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX,
          1'b0, 0, 0, 0, 0},
        '{qau_pkg::OP_MAT, HALF, HALF, HALF, HALF, 0, 0, 0, 0,
          1'b0, 0, 0, 0, 0},
        '{OP_SPARE, QMAX, QMIN, -1, 1, QMIN, QMAX, 1, -1,
          1'b0, 0, 0, 0, 0},
        '{OP_SPARE, 0, 0, 0, 0, 0, 0, 0, 0,
          1'b0, 0, 0, 0, 0}
    };

    function automatic longint q_sat(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        return q_sat(a + b);
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        return q_sat(a - b);
    endfunction

    // operands stay within 32 bits, so the raw product fits in 64
    function automatic longint q_mul(input longint a, input longint b);
        return q_sat((a * b) >>> FB);
    endfunction

    function automatic longint q_dbl(input longint a);
        return q_add(a, a);
    endfunction

    function automatic void push_word(input longint c0, input longint c1, input longint c2,
                                      input longint c3, input logic last);
        t_word w;
        w.c0 = t_q'(c0);
        w.c1 = t_q'(c1);
        w.c2 = t_q'(c2);
        w.c3 = t_q'(c3);
        w.last = last;
        pending_words.push_back(w);
    endfunction

    // Work out the result words a command word produces and queue them.
    function automatic void book_results(input t_row r);
        longint x, y, z, w, bx, by, bz, bw;
        longint uv0, uv1, uv2, uuv0, uuv1, uuv2, tw, one;
        longint tx, ty, tz, twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
        x = $signed(r.ax);
        y = $signed(r.ay);
        z = $signed(r.az);
        w = $signed(r.aw);
        bx = $signed(r.bx);
        by = $signed(r.by);
        bz = $signed(r.bz);
        bw = $signed(r.bw);
        n_ops[r.op]++;
        if (r.typed && (r.op == qau_pkg::OP_MUL || r.op == qau_pkg::OP_ROT)) begin
            push_word($signed(r.e0), $signed(r.e1), $signed(r.e2), $signed(r.e3), 1'b1);
            return;
        end
        case (r.op)
            qau_pkg::OP_MUL: begin
                push_word(q_sub(q_add(q_add(q_mul(w, bx), q_mul(x, bw)), q_mul(y, bz)),
                                q_mul(z, by)),
                          q_sub(q_add(q_add(q_mul(w, by), q_mul(y, bw)), q_mul(z, bx)),
                                q_mul(x, bz)),
                          q_sub(q_add(q_add(q_mul(w, bz), q_mul(z, bw)), q_mul(x, by)),
                                q_mul(y, bx)),
                          q_sub(q_sub(q_sub(q_mul(w, bw), q_mul(x, bx)), q_mul(y, by)),
                                q_mul(z, bz)),
                          1'b1);
            end
            qau_pkg::OP_ROT: begin
                tw = q_dbl(w);
                uv0 = q_sub(q_mul(y, bz), q_mul(z, by));
                uv1 = q_sub(q_mul(z, bx), q_mul(x, bz));
                uv2 = q_sub(q_mul(x, by), q_mul(y, bx));
                uuv0 = q_sub(q_mul(y, uv2), q_mul(z, uv1));
                uuv1 = q_sub(q_mul(z, uv0), q_mul(x, uv2));
                uuv2 = q_sub(q_mul(x, uv1), q_mul(y, uv0));
                push_word(q_add(q_add(bx, q_mul(uv0, tw)), q_dbl(uuv0)),
                          q_add(q_add(by, q_mul(uv1, tw)), q_dbl(uuv1)),
                          q_add(q_add(bz, q_mul(uv2, tw)), q_dbl(uuv2)),
                          0, 1'b1);
            end
            qau_pkg::OP_MAT: begin
                one = q_sat(64'sd1 <<< FB);
                tx = q_dbl(x);
                ty = q_dbl(y);
                tz = q_dbl(z);
                twx = q_mul(tx, w);
                twy = q_mul(ty, w);
                twz = q_mul(tz, w);
                txx = q_mul(tx, x);
                txy = q_mul(ty, x);
                txz = q_mul(tz, x);
                tyy = q_mul(ty, y);
                tyz = q_mul(tz, y);
                tzz = q_mul(tz, z);
                push_word(q_sub(one, q_add(tyy, tzz)), q_sub(txy, twz), q_add(txz, twy),
                          0, 1'b0);
                push_word(q_add(txy, twz), q_sub(one, q_add(txx, tzz)), q_sub(tyz, twx),
                          0, 1'b0);
                push_word(q_sub(txz, twy), q_add(tyz, twx), q_sub(one, q_add(txx, tyy)),
                          0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Mix of rails, values near one LSB, moderate Q16.16 values and full-range noise.
    function automatic t_q rand_q();
        case ($urandom_range(0, 9))
            0: return QMAX;
            1: return QMIN;
            2: return t_q'(int'($urandom_range(0, 6)) - 3);
            3, 4, 5: return t_q'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return t_q'($urandom);
        endcase
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int pick;
        pick = $urandom_range(0, 15);
        r = '0;
        if (pick < 5) r.op = qau_pkg::OP_MUL;
        else if (pick < 10) r.op = qau_pkg::OP_ROT;
        else if (pick < 14) r.op = qau_pkg::OP_MAT;
        else r.op = OP_SPARE;
        r.ax = rand_q();
        r.ay = rand_q();
        r.az = rand_q();
        r.aw = rand_q();
        r.bx = rand_q();
        r.by = rand_q();
        r.bz = rand_q();
        r.bw = rand_q();
        return r;
    endfunction

    // Present one command word after a gap and hold it until the unit takes it.
    task automatic issue(input t_row r, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= r.op;
        i_a_x <= r.ax;
        i_a_y <= r.ay;
        i_a_z <= r.az;
        i_a_w <= r.aw;
        i_b_x <= r.bx;
        i_b_y <= r.by;
        i_b_z <= r.bz;
        i_b_w <= r.bw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book_results(r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                $error("result word with none pending: %0d %0d %0d %0d last %0b",
                       o_out_0, o_out_1, o_out_2, o_out_3, o_last);
                n_errors++;
            end else begin
                got_word = pending_words.pop_front();
                check_field("out_0", $signed(got_word.c0), o_out_0);
                check_field("out_1", $signed(got_word.c1), o_out_1);
                check_field("out_2", $signed(got_word.c2), o_out_2);
                check_field("out_3", $signed(got_word.c3), o_out_3);
                check_field("last", got_word.last, o_last);
                n_checked++;
            end
        end
    end

    // Trip when neither a command nor a result word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_words.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int gap;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) issue(dir_rows[k], $urandom_range(0, 3));
        wait_drained();
        for (int k = 0; k < N_RAND; k++) begin
            // hold off once mid-run until the result queue is empty
            if (k == 130) wait_drained();
            gap = (k >= 60 && k < 100) ? 0 : $urandom_range(0, 3);
            issue(rand_row(), gap);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d multiply, %0d rotate, %0d matrix and %0d unused-op words,",
                 n_ops[qau_pkg::OP_MUL], n_ops[qau_pkg::OP_ROT],
                 n_ops[qau_pkg::OP_MAT], n_ops[OP_SPARE]);
        $display("with rail, rounding and back-to-back cases; %0d result words checked.",
                 n_checked);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
